FILE: sv/pulse_timed_frame_transmitter_unit_defines.svh
// assertion macros for the file that checks itself
`ifndef PULSE_TIMED_FRAME_TRANSMITTER_UNIT_DEFINES_SVH
`define PULSE_TIMED_FRAME_TRANSMITTER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PTFT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PTFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ptft_pkg.sv
package ptft_pkg;

  localparam int FRAME_BITS = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int BITPOS_W   = $clog2(FRAME_BITS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_UNIT_ID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_CODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_GAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_GAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_GAP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_UP    = 3'd5;

  localparam logic [15:0] RST_UNIT_ID     = 16'd66;
  localparam logic [7:0]  RST_MODULE_CODE = 8'd9;
  localparam logic [15:0] RST_LOCK_GAP    = 16'd2750;
  localparam logic [15:0] RST_SHORT_GAP   = 16'd275;
  localparam logic [15:0] RST_LONG_GAP    = 16'd1225;
  localparam logic [15:0] RST_PULSE_UP    = 16'd275;

  localparam logic       KIND_TICK    = 1'b0;
  localparam logic       KIND_COMMAND = 1'b1;
  localparam logic [7:0] CMD_MIN      = 8'd1;
  localparam logic [7:0] CMD_MAX      = 8'd6;

  typedef enum logic [1:0] {
    STATUS_NONE    = 2'd0,
    STATUS_STARTED = 2'd1,
    STATUS_INVALID = 2'd2,
    STATUS_BUSY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LOCK_HIGH  = 3'd1,
    PH_LOCK_LOW   = 3'd2,
    PH_BIT_HIGH   = 3'd3,
    PH_BIT_LOW    = 3'd4,
    PH_FINAL_HIGH = 3'd5
  } phase_t;

  typedef struct packed {
    logic       is_cmd;
    logic       cmd_ok;
    logic [7:0] cmd;
  } queue_entry_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } queue_ctrl_t;

endpackage

FILE: sv/ptft_in_if.sv
interface ptft_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] command_byte;

  modport source(output valid, output func, output command_byte, input ready);
  modport sink(input valid, input func, input command_byte, output ready);
endinterface

FILE: sv/ptft_out_if.sv
interface ptft_out_if;
  logic       valid;
  logic       ready;
  logic       line_level;
  logic       busy_res;
  logic [1:0] status;

  modport source(output valid, output line_level, output busy_res, output status,
                 input ready);
  modport sink(input valid, input line_level, input busy_res, input status,
               output ready);
endinterface

FILE: sv/ptft_front.sv
module ptft_front (
  input  logic                   clk,
  input  logic                   rst,
  ptft_in_if.sink                in_ch,
  output ptft_pkg::queue_entry_t head,
  input  logic                   pop,
  output logic                   head_valid,
  output logic [1:0]             fill
);

  ptft_pkg::queue_entry_t slot [2];
  ptft_pkg::queue_entry_t entry;
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;

  // classify the incoming word
  always_comb begin
    entry.is_cmd = (in_ch.func == ptft_pkg::KIND_COMMAND);
    entry.cmd_ok = (in_ch.command_byte >= ptft_pkg::CMD_MIN) &&
                   (in_ch.command_byte <= ptft_pkg::CMD_MAX);
    entry.cmd    = in_ch.command_byte;
  end

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (count != 2'd0);
  assign head        = slot[rd_ptr];
  assign fill        = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= entry;
    end
  end

endmodule

FILE: sv/ptft_back.sv
module ptft_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ptft_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptft_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  ptft_pkg::queue_entry_t               head,
  input  logic                                 head_valid,
  output ptft_pkg::queue_ctrl_t                qctl,
  ptft_out_if.source                           out_ch
);

  logic [15:0] unit_id;
  logic [7:0]  module_code;
  logic [15:0] lock_gap_time;
  logic [15:0] short_gap_time;
  logic [15:0] long_gap_time;
  logic [15:0] pulse_up_time;

  ptft_pkg::phase_t phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [ptft_pkg::FRAME_BITS-1:0] frame_bits, frame_bits_next;
  logic [ptft_pkg::BITPOS_W-1:0] bit_position, bit_position_next;
  logic second_half, second_half_next;
  logic line_out, line_out_next;
  ptft_pkg::status_t status_next;

  logic        take;
  logic [15:0] seg_len;
  logic [15:0] tick_inc;
  logic        seg_end;
  logic [ptft_pkg::BITPOS_W-1:0] pos_inc;

  assign take       = head_valid && (!out_ch.valid || out_ch.ready);
  assign qctl.valid = head_valid;
  assign qctl.pop   = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_id        <= ptft_pkg::RST_UNIT_ID;
      module_code    <= ptft_pkg::RST_MODULE_CODE;
      lock_gap_time  <= ptft_pkg::RST_LOCK_GAP;
      short_gap_time <= ptft_pkg::RST_SHORT_GAP;
      long_gap_time  <= ptft_pkg::RST_LONG_GAP;
      pulse_up_time  <= ptft_pkg::RST_PULSE_UP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptft_pkg::REG_UNIT_ID:     unit_id        <= cfg_data;
        ptft_pkg::REG_MODULE_CODE: module_code    <= cfg_data[7:0];
        ptft_pkg::REG_LOCK_GAP:    lock_gap_time  <= cfg_data;
        ptft_pkg::REG_SHORT_GAP:   short_gap_time <= cfg_data;
        ptft_pkg::REG_LONG_GAP:    long_gap_time  <= cfg_data;
        ptft_pkg::REG_PULSE_UP:    pulse_up_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  // the frame shifts left as bits go out, so the current bit is the msb
  always_comb begin
    unique case (phase)
      ptft_pkg::PH_LOCK_HIGH,
      ptft_pkg::PH_BIT_HIGH,
      ptft_pkg::PH_FINAL_HIGH: seg_len = pulse_up_time;
      ptft_pkg::PH_LOCK_LOW:   seg_len = lock_gap_time;
      ptft_pkg::PH_BIT_LOW:
        seg_len = (frame_bits[ptft_pkg::FRAME_BITS-1] ^ second_half) ?
                  short_gap_time : long_gap_time;
      default: seg_len = 16'd0;
    endcase
  end

  assign tick_inc = tick_count + 16'd1;
  assign seg_end  = (tick_inc == 16'd0) || (tick_inc >= seg_len);
  assign pos_inc  = bit_position + ptft_pkg::BITPOS_W'(1);

  // next state
  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    frame_bits_next   = frame_bits;
    bit_position_next = bit_position;
    second_half_next  = second_half;
    line_out_next     = line_out;
    if (take) begin
      if (head.is_cmd) begin
        if (phase == ptft_pkg::PH_IDLE && head.cmd_ok) begin
          frame_bits_next   = {unit_id, module_code, head.cmd};
          phase_next        = ptft_pkg::PH_LOCK_HIGH;
          tick_count_next   = 16'd0;
          bit_position_next = '0;
          second_half_next  = 1'b0;
          line_out_next     = 1'b1;
        end
      end else if (phase != ptft_pkg::PH_IDLE) begin
        tick_count_next = tick_inc;
        if (seg_end) begin
          tick_count_next = 16'd0;
          unique case (phase)
            ptft_pkg::PH_LOCK_HIGH: begin
              phase_next    = ptft_pkg::PH_LOCK_LOW;
              line_out_next = 1'b0;
            end
            ptft_pkg::PH_LOCK_LOW: begin
              phase_next    = ptft_pkg::PH_BIT_HIGH;
              line_out_next = 1'b1;
            end
            ptft_pkg::PH_BIT_HIGH: begin
              phase_next    = ptft_pkg::PH_BIT_LOW;
              line_out_next = 1'b0;
            end
            ptft_pkg::PH_BIT_LOW: begin
              line_out_next = 1'b1;
              if (!second_half) begin
                second_half_next = 1'b1;
                phase_next       = ptft_pkg::PH_BIT_HIGH;
              end else begin
                second_half_next  = 1'b0;
                bit_position_next = pos_inc;
                frame_bits_next   = {frame_bits[ptft_pkg::FRAME_BITS-2:0], 1'b0};
                phase_next = (pos_inc >= ptft_pkg::BITPOS_W'(ptft_pkg::FRAME_BITS)) ?
                             ptft_pkg::PH_FINAL_HIGH : ptft_pkg::PH_BIT_HIGH;
              end
            end
            default: begin
              phase_next    = ptft_pkg::PH_IDLE;
              line_out_next = 1'b0;
            end
          endcase
        end
      end
    end
  end

  // result status
  always_comb begin
    status_next = ptft_pkg::STATUS_NONE;
    if (head.is_cmd) begin
      priority if (phase != ptft_pkg::PH_IDLE) begin
        status_next = ptft_pkg::STATUS_BUSY;
      end else if (!head.cmd_ok) begin
        status_next = ptft_pkg::STATUS_INVALID;
      end else begin
        status_next = ptft_pkg::STATUS_STARTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ptft_pkg::PH_IDLE;
      tick_count   <= 16'd0;
      frame_bits   <= '0;
      bit_position <= '0;
      second_half  <= 1'b0;
      line_out     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      frame_bits   <= frame_bits_next;
      bit_position <= bit_position_next;
      second_half  <= second_half_next;
      line_out     <= line_out_next;
      if (take) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.line_level <= line_out_next;
      out_ch.busy_res   <= (phase_next != ptft_pkg::PH_IDLE);
      out_ch.status     <= status_next;
    end
  end

endmodule

FILE: sv/pulse_timed_frame_transmitter_unit.sv
// channel   dir  word
// in_ch     in   func, command_byte
// out_ch    out  line_level, busy_res, status
// cfg       in   cfg_we, cfg_index, cfg_data
//
// one word per cycle in and out while out_ch is not stalled; a result is registered
// when its word is taken from the head of the two-entry queue, set by the single state update
// reset clears the queue, the output valid flag and the frame state; config
// registers return to their defaults, no clearing pass
// a stalled output holds the back end; the queue then fills and in_ch.ready drops
`include "pulse_timed_frame_transmitter_unit_defines.svh"

module pulse_timed_frame_transmitter_unit (
  input  logic                            clk,
  input  logic                            rst,
  ptft_in_if.sink                         in_ch,
  ptft_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ptft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptft_pkg::CFG_DATA_W-1:0] cfg_data
);

  ptft_pkg::queue_entry_t head;
  ptft_pkg::queue_ctrl_t  qctl;
  logic                   head_valid;
  logic [1:0]             fill;

  ptft_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .head       (head),
    .pop        (qctl.pop),
    .head_valid (head_valid),
    .fill       (fill)
  );

  ptft_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (head),
    .head_valid (head_valid),
    .qctl       (qctl),
    .out_ch     (out_ch)
  );

  `PTFT_ASSERT_NOW(a_pop_needs_word, clk, rst, qctl.pop, qctl.valid, "pop from empty queue")
  `PTFT_ASSERT_NEXT(a_full_stalls_input, clk, rst, fill == 2'd2 && !qctl.pop, !in_ch.ready, "queue overrun")
  `PTFT_ASSERT_NOW(a_high_only_busy, clk, rst, out_ch.valid && out_ch.line_level, out_ch.busy_res, "line high while idle")
  `PTFT_ASSERT_NOW(a_start_goes_high, clk, rst, out_ch.valid && out_ch.status == ptft_pkg::STATUS_STARTED, out_ch.line_level && out_ch.busy_res, "frame start without high line")

endmodule
